// ----- rtl/idr_pkg.sv -----
package idr_pkg;

  localparam int unsigned SEED_NUM   = 523520;
  localparam int unsigned SEED_WIDTH = 11;
  localparam int unsigned SEED_DEPTH = 256;
  localparam logic [63:0] ONE_60     = 64'h1000_0000_0000_0000;
  localparam int unsigned LATENCY     = 22;

  typedef struct packed {
    logic [63:0] d1;
    logic [63:0] d0;
    logic        norm;
  } item_t;

  // Value under refinement plus the divisor it belongs to.
  typedef struct packed {
    logic [63:0] v;
    item_t       item;
  } val_t;

  typedef struct packed {
    logic        wrap;
    logic [63:0] v;
    item_t       item;
  } wrap_t;

  typedef struct packed {
    logic [63:0] r21;
    logic [63:0] v;
    logic [63:0] p;
    item_t       item;
  } adj_t;

  function automatic logic [63:0] d40_of(input logic [63:0] d);
    d40_of = {24'b0, d[63:24]} + 64'd1;
  endfunction

endpackage

// ----- rtl/invariant_divisor_reciprocal.sv -----
// Reciprocal unit for division by an invariant 128-bit divisor.
// Drive divisor_high and divisor_low with start high; the beat is taken at
// any rising edge where start is high and busy is low. Busy is high only
// while reset is asserted, so a new divisor may be started every cycle.
// Each beat yields exactly one result beat: done is high for one cycle with
// recip_two_by_one, recip_three_by_two and divisor_valid on the result ports.
// Each result passes through the chain of eight pipelined 64x64 multiplies
// (each forming partial products, then summing them) plus the seed lookup
// and correction stages.
// Throughput is one divisor per cycle.
// If bit 63 of divisor_high is clear, both reciprocals are zero and
// divisor_valid is low.
// Reset clears every valid bit in the pipeline; beats in flight are dropped.
// The receiver cannot stall: results must be captured in the done cycle.
module invariant_divisor_reciprocal
  import idr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] divisor_high,
  input  logic [63:0] divisor_low,
  output logic        done,
  output logic [63:0] recip_two_by_one,
  output logic [63:0] recip_three_by_two,
  output logic        divisor_valid
);

  logic        accept;
  item_t       in_item;
  logic        r21_vld;
  logic [63:0] r21;
  item_t       r21_item;

  assign busy    = rst;
  assign accept  = start && !busy;
  assign in_item = item_t'{d1: divisor_high, d0: divisor_low, norm: divisor_high[63]};

  idr_two_by_one u_two_by_one (
    .clk(clk), .rst(rst), .in_vld(accept), .in_item(in_item),
    .out_vld(r21_vld), .out_recip(r21), .out_item(r21_item)
  );

  idr_three_by_two u_three_by_two (
    .clk(clk), .rst(rst), .in_vld(r21_vld), .in_recip(r21), .in_item(r21_item),
    .out_vld(done), .out_two_by_one(recip_two_by_one),
    .out_three_by_two(recip_three_by_two), .out_norm(divisor_valid)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result beat missing after start beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result beat without a matching start beat");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !divisor_valid) |-> (recip_two_by_one == 64'd0
                                  && recip_three_by_two == 64'd0))
    else $error("nonzero reciprocal for unnormalized divisor");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY (divisor_valid == $past(divisor_high[63], LATENCY)))
    else $error("valid flag does not follow the divisor top bit");

endmodule

// ----- rtl/idr_mul64.sv -----
module idr_mul64
  import idr_pkg::*;
#(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [127:0]  prod,
  output logic [SW-1:0] side_out
);

  logic          pp_vld;
  logic [63:0]   pp_ll;
  logic [63:0]   pp_lh;
  logic [63:0]   pp_hl;
  logic [63:0]   pp_hh;
  logic [SW-1:0] pp_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      pp_vld  <= in_vld;
      out_vld <= pp_vld;
    end
  end

  // First stage forms four 32x32 partial products, second stage sums them.
  always_ff @(posedge clk) begin
    pp_ll    <= a[31:0] * b[31:0];
    pp_lh    <= a[31:0] * b[63:32];
    pp_hl    <= a[63:32] * b[31:0];
    pp_hh    <= a[63:32] * b[63:32];
    pp_side  <= side_in;
    prod     <= {64'b0, pp_ll} + {32'b0, pp_lh, 32'b0} + {32'b0, pp_hl, 32'b0}
                + {pp_hh, 64'b0};
    side_out <= pp_side;
  end

endmodule

// ----- rtl/idr_two_by_one.sv -----
module idr_two_by_one
  import idr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  item_t       in_item,
  output logic        out_vld,
  output logic [63:0] out_recip,
  output item_t       out_item
);

  localparam int VW = $bits(val_t);
  localparam int WW = $bits(wrap_t);

  logic [SEED_WIDTH-1:0] seed_rom [SEED_DEPTH];

  for (genvar i = 0; i < SEED_DEPTH; i++) begin : g_seed
    localparam int unsigned SEED_VAL = SEED_NUM / (SEED_DEPTH + i);
    assign seed_rom[i] = SEED_WIDTH'(SEED_VAL);
  end

  logic [SEED_WIDTH-1:0]   seed;
  logic                    r0_vld;
  logic [SEED_WIDTH-1:0]   r0_v0;
  logic [2*SEED_WIDTH-1:0] r0_sq;
  item_t                   r0_item;

  // The top bit of a normalized word is one, so bits 62:55 index the table.
  assign seed = seed_rom[in_item.d1[62:55]];

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_vld <= 1'b0;
    end else begin
      r0_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    r0_v0   <= seed;
    r0_sq   <= seed * seed;
    r0_item <= in_item;
  end

  // First Newton step: v1 = v0*2^11 - (v0^2*d40 >> 40) - 1.
  logic          m2_vld;
  logic [127:0]  m2_p;
  logic [VW-1:0] m2_raw;
  val_t          m2_s;
  logic [63:0]   v1;

  idr_mul64 #(.SW(VW)) u_m2 (
    .clk(clk), .rst(rst), .in_vld(r0_vld),
    .a({42'b0, r0_sq}), .b(d40_of(r0_item.d1)),
    .side_in(VW'(val_t'{v: {53'b0, r0_v0}, item: r0_item})),
    .out_vld(m2_vld), .prod(m2_p), .side_out(m2_raw)
  );

  assign m2_s = val_t'(m2_raw);
  assign v1   = {m2_s.v[52:0], 11'b0} - {40'b0, m2_p[63:40]} - 64'd1;

  logic          m3_vld;
  logic [127:0]  m3_p;
  logic [VW-1:0] m3_raw;
  val_t          m3_s;
  logic [63:0]   e1;

  idr_mul64 #(.SW(VW)) u_m3 (
    .clk(clk), .rst(rst), .in_vld(m2_vld),
    .a(v1), .b(d40_of(m2_s.item.d1)),
    .side_in(VW'(val_t'{v: v1, item: m2_s.item})),
    .out_vld(m3_vld), .prod(m3_p), .side_out(m3_raw)
  );

  assign m3_s = val_t'(m3_raw);
  assign e1   = ONE_60 - m3_p[63:0];

  // Second Newton step: v2 = v1*2^13 + (v1*e1 >> 47).
  logic          m4_vld;
  logic [127:0]  m4_p;
  logic [VW-1:0] m4_raw;
  val_t          m4_s;
  logic [63:0]   v2;

  idr_mul64 #(.SW(VW)) u_m4 (
    .clk(clk), .rst(rst), .in_vld(m3_vld),
    .a(m3_s.v), .b(e1), .side_in(m3_raw),
    .out_vld(m4_vld), .prod(m4_p), .side_out(m4_raw)
  );

  assign m4_s = val_t'(m4_raw);
  assign v2   = {m4_s.v[50:0], 13'b0} + {47'b0, m4_p[63:47]};

  logic          m5_vld;
  logic [127:0]  m5_p;
  logic [VW-1:0] m5_raw;
  val_t          m5_s;
  logic [63:0]   e2;

  idr_mul64 #(.SW(VW)) u_m5 (
    .clk(clk), .rst(rst), .in_vld(m4_vld),
    .a(v2), .b({1'b0, m4_s.item.d1[63:1]} + 64'd1),
    .side_in(VW'(val_t'{v: v2, item: m4_s.item})),
    .out_vld(m5_vld), .prod(m5_p), .side_out(m5_raw)
  );

  assign m5_s = val_t'(m5_raw);
  assign e2   = ({1'b0, m5_s.v[63:1]} & {64{m5_s.item.d1[0]}}) - m5_p[63:0];

  logic          m6_vld;
  logic [127:0]  m6_p;
  logic [VW-1:0] m6_raw;
  val_t          m6_s;

  idr_mul64 #(.SW(VW)) u_m6 (
    .clk(clk), .rst(rst), .in_vld(m5_vld),
    .a(m5_s.v), .b(e2), .side_in(m5_raw),
    .out_vld(m6_vld), .prod(m6_p), .side_out(m6_raw)
  );

  assign m6_s = val_t'(m6_raw);

  logic        r3_vld;
  logic [63:0] r3_v;
  item_t       r3_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_vld <= 1'b0;
    end else begin
      r3_vld <= m6_vld;
    end
  end

  always_ff @(posedge clk) begin
    r3_v    <= {m6_s.v[32:0], 31'b0} + {1'b0, m6_p[127:65]};
    r3_item <= m6_s.item;
  end

  // Final correction: q = hi((2^64 + v3 + 1) * d) mod 2^64. When v3 + 1 wraps
  // to zero, the missing 2^64 term contributes one more d to the high word.
  logic          m7_vld;
  logic [127:0]  m7_p;
  logic [WW-1:0] m7_raw;
  wrap_t         m7_s;

  idr_mul64 #(.SW(WW)) u_m7 (
    .clk(clk), .rst(rst), .in_vld(r3_vld),
    .a(r3_v + 64'd1), .b(r3_item.d1),
    .side_in(WW'(wrap_t'{wrap: &r3_v, v: r3_v, item: r3_item})),
    .out_vld(m7_vld), .prod(m7_p), .side_out(m7_raw)
  );

  assign m7_s = wrap_t'(m7_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= m7_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_recip <= m7_s.v - m7_p[127:64] - m7_s.item.d1
                 - (m7_s.item.d1 & {64{m7_s.wrap}});
    out_item  <= m7_s.item;
  end

endmodule

// ----- rtl/idr_three_by_two.sv -----
module idr_three_by_two
  import idr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [63:0] in_recip,
  input  item_t       in_item,
  output logic        out_vld,
  output logic [63:0] out_two_by_one,
  output logic [63:0] out_three_by_two,
  output logic        out_norm
);

  localparam int VW = $bits(val_t);
  localparam int AW = $bits(adj_t);

  logic          m8_vld;
  logic [127:0]  m8_p;
  logic [VW-1:0] m8_raw;
  val_t          m8_s;

  idr_mul64 #(.SW(VW)) u_m8 (
    .clk(clk), .rst(rst), .in_vld(in_vld),
    .a(in_item.d1), .b(in_recip),
    .side_in(VW'(val_t'{v: in_recip, item: in_item})),
    .out_vld(m8_vld), .prod(m8_p), .side_out(m8_raw)
  );

  assign m8_s = val_t'(m8_raw);

  logic        a_vld;
  logic        a_c;
  logic [63:0] a_p;
  val_t        a_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= m8_vld;
    end
  end

  always_ff @(posedge clk) begin
    {a_c, a_p} <= {1'b0, m8_p[63:0]} + {1'b0, m8_s.item.d0};
    a_s        <= m8_s;
  end

  // A carry out of d1*v + d0 means the estimate is one or two too large.
  logic        a_ge;
  logic [63:0] a_p1;
  logic [63:0] adj_v;
  logic [63:0] adj_p;

  assign a_ge  = a_p >= a_s.item.d1;
  assign a_p1  = a_p - a_s.item.d1;
  assign adj_v = a_s.v - {63'b0, a_c} - {63'b0, a_c & a_ge};
  assign adj_p = !a_c ? a_p : (a_ge ? a_p1 - a_s.item.d1 : a_p1);

  logic b_vld;
  adj_t b_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_s <= adj_t'{r21: a_s.v, v: adj_v, p: adj_p, item: a_s.item};
  end

  logic          m9_vld;
  logic [127:0]  m9_p;
  logic [AW-1:0] m9_raw;
  adj_t          m9_s;
  logic          c2;
  logic [63:0]   p2;
  logic          over;
  logic [63:0]   r32;

  idr_mul64 #(.SW(AW)) u_m9 (
    .clk(clk), .rst(rst), .in_vld(b_vld),
    .a(b_s.v), .b(b_s.item.d0), .side_in(AW'(b_s)),
    .out_vld(m9_vld), .prod(m9_p), .side_out(m9_raw)
  );

  assign m9_s      = adj_t'(m9_raw);
  assign {c2, p2}  = {1'b0, m9_s.p} + {1'b0, m9_p[127:64]};
  assign over      = (p2 > m9_s.item.d1)
                     || (p2 == m9_s.item.d1 && m9_p[63:0] >= m9_s.item.d0);
  assign r32       = m9_s.v - {63'b0, c2} - {63'b0, c2 & over};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= m9_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_two_by_one   <= m9_s.r21 & {64{m9_s.item.norm}};
    out_three_by_two <= r32 & {64{m9_s.item.norm}};
    out_norm         <= m9_s.item.norm;
  end

endmodule

// ----- tb/sv/invariant_divisor_reciprocal_checker.sv -----
`timescale 1ns / 100ps

module invariant_divisor_reciprocal_checker
  import idr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] divisor_high,
  input  logic [63:0] divisor_low,
  input  logic        done,
  input  logic [63:0] recip_two_by_one,
  input  logic [63:0] recip_three_by_two,
  input  logic        divisor_valid,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [63:0] r21;
    logic [63:0] r32;
    logic        valid;
  } recip_t;

  recip_t expected_recips[$];

  assign pending = expected_recips.size();

  initial errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [127:0] mul128(input logic [63:0] a, input logic [63:0] b);
    mul128 = {64'b0, a} * {64'b0, b};
  endfunction

  // Newton-refined 2-by-1 reciprocal; d has its top bit set.
  function automatic logic [63:0] two_by_one(input logic [63:0] d);
    logic [63:0] d9, d40, d63, v0, v1, v2, e, v3, q;
    logic [127:0] prod;
    d9  = {55'b0, d[63:55]};
    d40 = {24'b0, d[63:24]} + 64'd1;
    d63 = {1'b0, d[63:1]} + 64'd1;
    v0  = 64'd523520 / d9;
    v1  = (v0 << 11) - ((v0 * v0 * d40) >> 40) - 64'd1;
    v2  = (v1 << 13) + ((v1 * (64'h1000_0000_0000_0000 - v1 * d40)) >> 47);
    e   = ((v2 >> 1) & {64{d[0]}}) - v2 * d63;
    prod = mul128(v2, e);
    v3  = (v2 << 31) + (prod[127:64] >> 1);
    if (v3 == '1) begin
      q = d + d;
    end else begin
      prod = mul128(v3 + 64'd1, d);
      q = prod[127:64] + d;
    end
    two_by_one = v3 - q;
  endfunction

  function automatic logic [63:0] three_by_two(input logic [63:0] d1, input logic [63:0] d0,
                                               input logic [63:0] vin);
    logic [63:0] v, p;
    logic [127:0] t;
    v = vin;
    p = d1 * v + d0;
    if (p < d0) begin
      v--;
      if (p >= d1) begin
        v--;
        p -= d1;
      end
      p -= d1;
    end
    t = mul128(v, d0);
    p += t[127:64];
    if (p < t[127:64]) begin
      v--;
      if (p > d1 || (p == d1 && t[63:0] >= d0)) v--;
    end
    three_by_two = v;
  endfunction

  always @(posedge clk) begin
    recip_t r, w;
    if (!rst && done) begin
      if (expected_recips.size() == 0) begin
        $display("%0t result beat with nothing expected", $realtime);
        errors++;
      end else begin
        w = expected_recips.pop_front();
        if (recip_two_by_one !== w.r21) report("recip_two_by_one", recip_two_by_one, w.r21);
        if (recip_three_by_two !== w.r32)
          report("recip_three_by_two", recip_three_by_two, w.r32);
        if (divisor_valid !== w.valid) report("divisor_valid", divisor_valid, w.valid);
      end
    end
    if (!rst && start && !busy) begin
      r = '0;
      if (divisor_high[63]) begin
        r.r21 = two_by_one(divisor_high);
        r.r32 = three_by_two(divisor_high, divisor_low, r.r21);
        r.valid = 1'b1;
      end
      expected_recips.push_back(r);
    end
  end

endmodule

// ----- tb/sv/invariant_divisor_reciprocal_tb.sv -----
`timescale 1ns / 100ps

module invariant_divisor_reciprocal_tb;
  import idr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] divisor_high = '0;
  logic [63:0] divisor_low = '0;
  logic        done;
  logic [63:0] recip_two_by_one, recip_three_by_two;
  logic        divisor_valid;
  int          errors, pending;
  int          cycles = 0;

  always #4 clk = ~clk;

  invariant_divisor_reciprocal u_dut (.*);
  invariant_divisor_reciprocal_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  // Holds one beat on the ports until it is taken, with an optional idle gap first.
  task automatic send_divisor(input logic [63:0] hi, input logic [63:0] lo, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    divisor_high <= hi;
    divisor_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] shaped(input int kind);
    case (kind)
      0: shaped = '0;
      1: shaped = '1;
      2: shaped = 64'h8000_0000_0000_0000;
      3: shaped = rand64() | 64'hFF80_0000_0000_0000;
      4: shaped = rand64() >> $urandom_range(0, 63);
      5: shaped = ~(rand64() >> $urandom_range(0, 63));
      default: shaped = rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] hi, lo;
    int gap;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes of both words, seed table ends, unnormalized divisors.
    send_divisor(64'h8000_0000_0000_0000, 64'h0, 0);
    send_divisor(64'h8000_0000_0000_0000, '1, 0);
    send_divisor('1, '1, 0);
    send_divisor('1, 64'h0, 0);
    send_divisor(64'hFFFF_FFFF_FFFF_FFFE, '1, 1);
    send_divisor(64'h8000_0000_0000_0001, 64'h1, 0);
    send_divisor(64'h80FF_FFFF_FFFF_FFFF, '1, 0);
    send_divisor(64'hFF00_0000_0000_0000, 64'h8000_0000_0000_0000, 2);
    send_divisor(64'h7FFF_FFFF_FFFF_FFFF, '1, 0);
    send_divisor(64'h0, 64'h0, 0);
    send_divisor(64'h1, 64'h5555_5555_5555_5555, 0);
    send_divisor(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0);
    send_divisor(64'hD555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    for (int i = 0; i < 1500; i++) begin
      hi = shaped($urandom_range(0, 9));
      if ($urandom_range(0, 9) != 0) hi[63] = 1'b1;
      lo = shaped($urandom_range(0, 9));
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (i % 200 < 40) gap = 0;
      send_divisor(hi, lo, gap);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
